### hdl/mscc_pkg.sv
// ----------------------------------------------------------------------------
// mscc_pkg
// Shared types, constants and instruction codes of the music sequencer
// channel core.
// ----------------------------------------------------------------------------
package mscc_pkg;

  // Storage sizes
  localparam int unsigned REG_COUNT  = 16;
  localparam int unsigned STACK_SIZE = 32;

  // Stack level counts 0..STACK_SIZE; the store is split in two banks by
  // address parity
  localparam int unsigned LVL_W      = $clog2(STACK_SIZE + 1);
  localparam int unsigned BANK_DEPTH = (STACK_SIZE + 1) / 2;
  localparam int unsigned ROW_W      = $clog2(BANK_DEPTH);

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_TUSER_W = 2;

  // Highest direct note pitch + 1, also the direct rest code
  localparam logic [7:0] NOTE_REST_CODE = 8'd96;
  // Divisor of the percent instruction and its 16-bit fixed-point reciprocal
  localparam logic [7:0]  PRC_DIV   = 8'd100;
  localparam logic [9:0]  PRC_RECIP = 10'd655;

  // Command reported per instruction
  typedef enum logic [1:0] {
    KIND_CONTINUE = 2'd0,
    KIND_PLAY     = 2'd1,
    KIND_REST     = 2'd2,
    KIND_HALT     = 2'd3
  } mscc_kind_e;

  // Module interface request
  typedef enum logic [1:0] {
    MREQ_NONE = 2'd0,
    MREQ_GET  = 2'd1,
    MREQ_SET  = 2'd2,
    MREQ_CALL = 2'd3
  } mscc_mreq_e;

  // Fault status
  typedef enum logic [1:0] {
    FAULT_OK      = 2'd0,
    FAULT_ILLEGAL = 2'd1,
    FAULT_STACK   = 2'd2
  } mscc_fault_e;

  // Register-form selector (opcode bits 5:4 of 0x80..0xBF)
  localparam logic [1:0] AF_LD   = 2'd0;
  localparam logic [1:0] AF_NOTE = 2'd1;
  localparam logic [1:0] AF_LOOP = 2'd2;

  // Control-form opcodes (opcode minus 0xC0)
  localparam logic [5:0] OPC_CALL = 6'h00;
  localparam logic [5:0] OPC_JMP  = 6'h01;
  localparam logic [5:0] OPC_JEQ  = 6'h02;
  localparam logic [5:0] OPC_JNE  = 6'h03;
  localparam logic [5:0] OPC_JLE  = 6'h04;
  localparam logic [5:0] OPC_JLT  = 6'h05;
  localparam logic [5:0] OPC_JGE  = 6'h06;
  localparam logic [5:0] OPC_JGT  = 6'h07;
  localparam logic [5:0] OPC_MOV  = 6'h08;
  localparam logic [5:0] OPC_EXG  = 6'h09;
  localparam logic [5:0] OPC_ADD  = 6'h0A;
  localparam logic [5:0] OPC_SUB  = 6'h0B;
  localparam logic [5:0] OPC_PRC  = 6'h0C;
  localparam logic [5:0] OPC_CMP  = 6'h0D;
  localparam logic [5:0] OPC_REST = 6'h1B;
  localparam logic [5:0] OPC_MGET = 6'h1C;
  localparam logic [5:0] OPC_MSET = 6'h1D;

  // Extended form (opcode 0xFF), selected by x
  localparam logic [3:0] DX_PUSH  = 4'd0;
  localparam logic [3:0] DX_POP   = 4'd1;
  localparam logic [3:0] DX_MCALL = 4'd2;
  localparam logic [3:0] DX_SYS   = 4'd15;

  // System operations (x = 15), selected by y
  localparam logic [3:0] SY_NOP      = 4'd0;
  localparam logic [3:0] SY_RET      = 4'd1;
  localparam logic [3:0] SY_SLUR_ON  = 4'd5;
  localparam logic [3:0] SY_SLUR_OFF = 4'd6;
  localparam logic [3:0] SY_HALT     = 4'd15;

  // Stack operation for one instruction: data_lo goes to the current level,
  // data_hi to the one above it
  typedef struct packed {
    logic [1:0] push_cnt;
    logic [1:0] pop_cnt;
    logic [7:0] data_lo;
    logic [7:0] data_hi;
  } mscc_stk_cmd_t;

  // Stack status: level and the two topmost entries
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [7:0]       top_a;  // entry at level-1
    logic [7:0]       top_b;  // entry at level-2
  } mscc_stk_stat_t;

  // One result item
  typedef struct packed {
    mscc_kind_e  command_kind;
    logic [7:0]  pitch;
    logic [7:0]  length_count;
    logic [7:0]  length_divisor;
    logic [7:0]  next_fetch;
    logic [7:0]  procedure;
    logic        slur_on;
    mscc_mreq_e  module_request;
    logic [3:0]  module_slot;
    logic [7:0]  module_data;
    mscc_fault_e fault;
  } mscc_result_t;

endpackage

### hdl/music_sequencer_channel_core.sv
// ----------------------------------------------------------------------------
// music_sequencer_channel_core
// Executes one two-byte music channel instruction per input item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one instruction per beat (opcode and operand byte).
//   m_axis returns one result per instruction: the command (continue, play,
//   rest, halt) on tuser, and note length, next fetch address, procedure,
//   slur mode, module request and fault status on tdata.
//   An accepted instruction is held in the input register and executed from
//   there into the result register, which presents its result on m_axis.
//   Throughput is one instruction per cycle while the receiver does not
//   stall: register file, flags, fetch counter and stack top are read and
//   updated in the single execute step, which also holds the 8x8 multiply
//   and divide by 100 of the percent op.
//   When the receiver stalls, the result is held; one more instruction is
//   taken into the input register, then s_axis_tready_o drops.
//   Reset clears the registers, flags, counters and the stack level; the
//   stack memory is not cleared, as no entry is read before it is written.
// ----------------------------------------------------------------------------
module music_sequencer_channel_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Instruction stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] opcode_byte, [15:8] operand_byte
  input  logic [mscc_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // Result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [7:0] pitch, [15:8] length_count, [23:16] length_divisor,
  // [31:24] next_fetch, [39:32] procedure, [40] slur_on,
  // [42:41] module_request, [46:43] module_slot, [54:47] module_data,
  // [56:55] fault, [63:57] zero
  output logic [mscc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // [1:0] command_kind
  output logic [mscc_pkg::OUT_TUSER_W-1:0]   m_axis_tuser_o
);
  import mscc_pkg::*;

  // Handshake
  logic in_vld_q, out_vld_q, accept, advance;

  // Input register
  logic [7:0] op_q, arg_q;

  // Architectural state
  logic [7:0] rf_q [REG_COUNT];
  logic [7:0] rf_d [REG_COUNT];
  logic       eq_q, eq_d, gt_q, gt_d, slur_q, slur_d;
  logic [7:0] fc_q, fc_d, proc_q, proc_d;

  // Execute
  logic [3:0]     rn_idx, rx_idx, ry_idx;
  logic [7:0]     rn, rx, ry, fc_inc;
  logic [15:0]    prod;
  logic [25:0]    prod_scaled;
  logic [9:0]     quo_est;
  logic [15:0]    rem_est;
  logic [7:0]     prc_res;
  logic           jump;
  logic [LVL_W:0] lvl_ext;
  mscc_stk_cmd_t  stk_cmd, stk_cmd_gated;
  mscc_stk_stat_t stk_stat;
  mscc_result_t   res, res_q;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign m_axis_tvalid_o = out_vld_q;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tdata_i[7:0];
      arg_q <= s_axis_tdata_i[15:8];
    end
  end

  // Operand fields and register reads
  assign rn_idx = op_q[3:0];
  assign rx_idx = arg_q[7:4];
  assign ry_idx = arg_q[3:0];
  assign rn     = rf_q[rn_idx];
  assign rx     = rf_q[rx_idx];
  assign ry     = rf_q[ry_idx];
  assign fc_inc = fc_q + 8'd1;

  // Percent: (Ry*Rx)/100 by reciprocal estimate and one correction step
  assign prod        = ry * rx;
  assign prod_scaled = 26'(prod) * 26'(PRC_RECIP);
  assign quo_est     = prod_scaled[25:16];
  assign rem_est     = prod - 16'(quo_est * 16'(PRC_DIV));
  assign prc_res     = (rem_est >= 16'(PRC_DIV)) ? 8'(quo_est + 10'd1) : quo_est[7:0];

  assign lvl_ext = {1'b0, stk_stat.level};

  // Instruction decode and execute
  always_comb begin
    rf_d    = rf_q;
    eq_d    = eq_q;
    gt_d    = gt_q;
    slur_d  = slur_q;
    fc_d    = fc_inc;
    proc_d  = proc_q;
    jump    = 1'b0;
    stk_cmd = '0;
    res     = '0;
    res.command_kind   = KIND_CONTINUE;
    res.module_request = MREQ_NONE;
    res.fault          = FAULT_OK;

    priority if (!op_q[7]) begin
      // Direct note or rest
      if (op_q < NOTE_REST_CODE) begin
        res.command_kind   = KIND_PLAY;
        res.pitch          = op_q;
        res.length_count   = {4'd0, rx_idx} + 8'd1;
        res.length_divisor = {4'd0, ry_idx} + 8'd1;
      end else if (op_q == NOTE_REST_CODE) begin
        res.command_kind   = KIND_REST;
        res.length_count   = {4'd0, rx_idx} + 8'd1;
        res.length_divisor = {4'd0, ry_idx} + 8'd1;
      end else begin
        res.fault = FAULT_ILLEGAL;
      end
    end else if (!op_q[6]) begin
      // Register forms
      unique case (op_q[5:4])
        AF_LD: begin
          rf_d[rn_idx] = arg_q;
        end
        AF_NOTE: begin
          res.command_kind   = KIND_PLAY;
          res.pitch          = rn;
          res.length_count   = rx;
          res.length_divisor = ry;
        end
        AF_LOOP: begin
          if (rn != 8'd0) begin
            rf_d[rn_idx] = rn - 8'd1;
            fc_d         = arg_q;
          end
        end
        default: begin
          res.fault = FAULT_ILLEGAL;
        end
      endcase
    end else if (op_q != 8'hFF) begin
      // Control forms
      unique case (op_q[5:0])
        OPC_CALL: begin
          if (lvl_ext + (LVL_W+1)'(2) > (LVL_W+1)'(STACK_SIZE)) begin
            res.fault = FAULT_STACK;
          end else begin
            stk_cmd.push_cnt = 2'd2;
            stk_cmd.data_lo  = proc_q;
            stk_cmd.data_hi  = fc_inc;
            proc_d           = arg_q;
            fc_d             = 8'd0;
          end
        end
        OPC_JMP: jump = 1'b1;
        OPC_JEQ: jump = eq_q;
        OPC_JNE: jump = !eq_q;
        OPC_JLE: jump = eq_q || !gt_q;
        OPC_JLT: jump = !gt_q && !eq_q;
        OPC_JGE: jump = eq_q || gt_q;
        OPC_JGT: jump = gt_q;
        OPC_MOV: rf_d[ry_idx] = rx;
        OPC_EXG: begin
          rf_d[ry_idx] = rx;
          rf_d[rx_idx] = ry;
        end
        OPC_ADD: rf_d[ry_idx] = ry + rx;
        OPC_SUB: rf_d[ry_idx] = ry - rx;
        OPC_PRC: rf_d[ry_idx] = prc_res;
        OPC_CMP: begin
          eq_d = (rx == ry);
          gt_d = (ry > rx);
        end
        OPC_REST: begin
          res.command_kind   = KIND_REST;
          res.length_count   = rx;
          res.length_divisor = ry;
        end
        OPC_MGET: begin
          res.module_request = MREQ_GET;
          res.module_slot    = rx_idx;
        end
        OPC_MSET: begin
          res.module_request = MREQ_SET;
          res.module_slot    = ry_idx;
          res.module_data    = rx;
        end
        default: begin
          res.fault = FAULT_ILLEGAL;
        end
      endcase
      if (jump) begin
        fc_d = arg_q;
      end
    end else if (rx_idx != DX_SYS) begin
      // Extended forms
      unique case (rx_idx)
        DX_PUSH: begin
          if (lvl_ext >= (LVL_W+1)'(STACK_SIZE)) begin
            res.fault = FAULT_STACK;
          end else begin
            stk_cmd.push_cnt = 2'd1;
            stk_cmd.data_lo  = ry;
          end
        end
        DX_POP: begin
          if (stk_stat.level == '0) begin
            res.fault = FAULT_STACK;
          end else begin
            stk_cmd.pop_cnt = 2'd1;
            rf_d[ry_idx]    = stk_stat.top_a;
          end
        end
        DX_MCALL: begin
          res.module_request = MREQ_CALL;
          res.module_slot    = ry_idx;
        end
        default: begin
          res.fault = FAULT_ILLEGAL;
        end
      endcase
    end else begin
      // System operations
      unique case (ry_idx)
        SY_NOP: ;
        SY_RET: begin
          if (lvl_ext < (LVL_W+1)'(2)) begin
            res.fault = FAULT_STACK;
          end else begin
            stk_cmd.pop_cnt = 2'd2;
            fc_d            = stk_stat.top_a;
            proc_d          = stk_stat.top_b;
          end
        end
        SY_SLUR_ON:  slur_d = 1'b1;
        SY_SLUR_OFF: slur_d = 1'b0;
        SY_HALT:     res.command_kind = KIND_HALT;
        default: begin
          res.fault = FAULT_ILLEGAL;
        end
      endcase
    end

    res.next_fetch = fc_d;
    res.procedure  = proc_d;
    res.slur_on    = slur_d;
  end

  // Stack changes only when the instruction retires
  assign stk_cmd_gated = advance ? stk_cmd : '0;

  mscc_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd_gated),
    .stat_o (stk_stat)
  );

  // State commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_q[i] <= 8'd0;
      end
      eq_q   <= 1'b0;
      gt_q   <= 1'b0;
      slur_q <= 1'b0;
      fc_q   <= 8'd0;
      proc_q <= 8'd0;
    end else if (advance) begin
      rf_q   <= rf_d;
      eq_q   <= eq_d;
      gt_q   <= gt_d;
      slur_q <= slur_d;
      fc_q   <= fc_d;
      proc_q <= proc_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  // Output packing
  assign m_axis_tuser_o = res_q.command_kind;
  assign m_axis_tdata_o = {7'd0,
                           res_q.fault,
                           res_q.module_data,
                           res_q.module_slot,
                           res_q.module_request,
                           res_q.slur_on,
                           res_q.procedure,
                           res_q.next_fetch,
                           res_q.length_divisor,
                           res_q.length_count,
                           res_q.pitch};

endmodule

### hdl/mscc_stack.sv
// ----------------------------------------------------------------------------
// mscc_stack
// Call/push byte stack. Two parity banks give two writes (call) and two
// reads (return) per cycle; the top entry of each bank is prefetched into a
// register with write-through on the same row.
// ----------------------------------------------------------------------------
module mscc_stack (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mscc_pkg::mscc_stk_cmd_t cmd_i,
  output mscc_pkg::mscc_stk_stat_t stat_o
);
  import mscc_pkg::*;

  logic [LVL_W-1:0] level_q, level_d;
  logic [LVL_W-1:0] addr_lo, addr_hi;
  logic [LVL_W:0]   cnt_even, cnt_odd;

  logic [7:0] mem_even [BANK_DEPTH];
  logic [7:0] mem_odd  [BANK_DEPTH];

  logic             we_even, we_odd;
  logic [ROW_W-1:0] wrow_even, wrow_odd;
  logic [7:0]       wdat_even, wdat_odd;
  logic [ROW_W-1:0] rrow_even, rrow_odd;
  logic [7:0]       rd_even_q, rd_odd_q;

  // Level update
  assign level_d = level_q + LVL_W'(cmd_i.push_cnt) - LVL_W'(cmd_i.pop_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  // Steer pushed bytes to their bank by address parity
  assign addr_lo = level_q;
  assign addr_hi = level_q + LVL_W'(1);

  always_comb begin
    we_even   = 1'b0;
    wrow_even = ROW_W'(addr_lo >> 1);
    wdat_even = cmd_i.data_lo;
    we_odd    = 1'b0;
    wrow_odd  = ROW_W'(addr_lo >> 1);
    wdat_odd  = cmd_i.data_lo;
    if (cmd_i.push_cnt != 2'd0) begin
      if (!addr_lo[0]) begin
        we_even = 1'b1;
      end else begin
        we_odd = 1'b1;
      end
    end
    if (cmd_i.push_cnt == 2'd2) begin
      if (!addr_hi[0]) begin
        we_even   = 1'b1;
        wrow_even = ROW_W'(addr_hi >> 1);
        wdat_even = cmd_i.data_hi;
      end else begin
        we_odd   = 1'b1;
        wrow_odd = ROW_W'(addr_hi >> 1);
        wdat_odd = cmd_i.data_hi;
      end
    end
  end

  // Top row of each bank under the next level
  assign cnt_even  = ({1'b0, level_d} + (LVL_W+1)'(1)) >> 1;
  assign cnt_odd   = {1'b0, level_d} >> 1;
  assign rrow_even = ROW_W'(cnt_even - (LVL_W+1)'(1));
  assign rrow_odd  = ROW_W'(cnt_odd - (LVL_W+1)'(1));

  // Even bank
  always_ff @(posedge clk_i) begin
    if (we_even) begin
      mem_even[wrow_even] <= wdat_even;
    end
    rd_even_q <= (we_even && (wrow_even == rrow_even)) ? wdat_even : mem_even[rrow_even];
  end

  // Odd bank
  always_ff @(posedge clk_i) begin
    if (we_odd) begin
      mem_odd[wrow_odd] <= wdat_odd;
    end
    rd_odd_q <= (we_odd && (wrow_odd == rrow_odd)) ? wdat_odd : mem_odd[rrow_odd];
  end

  // Entry level-1 sits in the bank of its parity, level-2 in the other
  assign stat_o.level = level_q;
  assign stat_o.top_a = level_q[0] ? rd_even_q : rd_odd_q;
  assign stat_o.top_b = level_q[0] ? rd_odd_q  : rd_even_q;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the music sequencer channel core against a cycle-free instruction
// predictor. A table of directed instructions comes first: field extremes,
// every instruction form, illegal codes and stack errors. Random bursts
// follow: note runs, load/loop sequences, compare-and-branch, push/pop and
// call/return runs deep enough to overflow and underflow the stack, plus
// raw noise. Both stream sides idle and stall in several phases, and the
// result side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mscc_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 6;
  localparam int RANDOM_PER_PHASE = 75;
  localparam int NUM_PHASES       = 4;
  localparam int HOLD_CYCLES      = 64;
  localparam int DRAIN_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int NUM_DIRECTED     = 40;

  // Instruction form prefixes
  localparam logic [1:0] A_FORM  = 2'b10;
  localparam logic [1:0] C_FORM  = 2'b11;
  localparam logic [1:0] AF_BAD  = 2'd3;
  localparam logic [7:0] EXT_OP  = 8'hFF;

  logic                   clk     = 1'b0;
  logic                   rst_n   = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data  = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  music_sequencer_channel_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: channel registers, flags, fetch pointer and call stack
  logic [7:0]   chan_regs [REG_COUNT];
  logic         flag_eq;
  logic         flag_gt;
  logic         slur_mode;
  logic [7:0]   fetch_ptr;
  logic [7:0]   proc_num;
  int           stk_level;
  logic [7:0]   stack_mem [STACK_SIZE];

  mscc_result_t predicted_steps [$];
  logic [15:0]  instr_queue [$];
  mscc_result_t want_step;
  int           error_count   = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           holds_asked   = 0;
  int           holds_granted = 0;
  int           stall_left    = 0;
  int           quiet_cycles  = 0;

  int phase_send_idle  [NUM_PHASES] = '{0, 80, 0, 31};
  int phase_recv_stall [NUM_PHASES] = '{0, 0, 80, 31};

  typedef struct {
    logic [7:0]   op;
    logic [7:0]   arg;
    bit           typed;
    mscc_result_t want;
  } dir_row_t;

  // Directed instructions; rows with typed=1 carry their expected result.
  // Fetch pointer in the typed rows counts up from reset.
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // lowest pitch, shortest length
    '{8'd0, 8'h00, 1'b1,
      '{KIND_PLAY, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0, FAULT_OK}},
    // highest pitch, longest length
    '{8'd95, 8'hFF, 1'b1,
      '{KIND_PLAY, 8'd95, 8'd16, 8'd16, 8'd2, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0, FAULT_OK}},
    // direct rest
    '{NOTE_REST_CODE, 8'h0F, 1'b1,
      '{KIND_REST, 8'd0, 8'd1, 8'd16, 8'd3, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0, FAULT_OK}},
    // pitch just above the rest code is illegal
    '{NOTE_REST_CODE + 8'd1, 8'hA5, 1'b1,
      '{KIND_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd4, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0,
        FAULT_ILLEGAL}},
    // unused register form
    '{{A_FORM, AF_BAD, 4'hA}, 8'h33, 1'b1,
      '{KIND_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd5, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0,
        FAULT_ILLEGAL}},
    // pop from an empty stack
    '{EXT_OP, {DX_POP, 4'd3}, 1'b1,
      '{KIND_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd6, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0,
        FAULT_STACK}},
    // return with an empty stack
    '{EXT_OP, {DX_SYS, SY_RET}, 1'b1,
      '{KIND_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd7, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0,
        FAULT_STACK}},
    // unused control code
    '{{C_FORM, OPC_CMP + 6'd1}, 8'h00, 1'b1,
      '{KIND_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd8, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0,
        FAULT_ILLEGAL}},
    // unused extended selector
    '{EXT_OP, {4'd7, 4'hC}, 1'b1,
      '{KIND_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd9, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0,
        FAULT_ILLEGAL}},
    // unused system operation
    '{EXT_OP, {DX_SYS, 4'd2}, 1'b1,
      '{KIND_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd10, 8'd0, 1'b0, MREQ_NONE, 4'd0, 8'd0,
        FAULT_ILLEGAL}},
    // slur on
    '{EXT_OP, {DX_SYS, SY_SLUR_ON}, 1'b1,
      '{KIND_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd11, 8'd0, 1'b1, MREQ_NONE, 4'd0, 8'd0,
        FAULT_OK}},
    '{{A_FORM, AF_LD, 4'd3},  8'hC8, 1'b0, '0},
    '{{A_FORM, AF_LD, 4'd4},  8'h96, 1'b0, '0},
    '{{A_FORM, AF_LD, 4'd15}, 8'hFF, 1'b0, '0},
    '{{A_FORM, AF_NOTE, 4'd3}, 8'h4F, 1'b0, '0},
    '{{C_FORM, OPC_PRC}, 8'h34, 1'b0, '0},
    '{{C_FORM, OPC_CMP}, 8'h34, 1'b0, '0},
    '{{C_FORM, OPC_JLT}, 8'h40, 1'b0, '0},
    '{{C_FORM, OPC_JGT}, 8'h50, 1'b0, '0},
    '{{C_FORM, OPC_JLE}, 8'h60, 1'b0, '0},
    '{{C_FORM, OPC_JEQ}, 8'h70, 1'b0, '0},
    '{{C_FORM, OPC_JNE}, 8'h80, 1'b0, '0},
    '{{C_FORM, OPC_JGE}, 8'h90, 1'b0, '0},
    '{{C_FORM, OPC_JMP}, 8'hFF, 1'b0, '0},
    '{{C_FORM, OPC_MOV}, 8'h3A, 1'b0, '0},
    '{{C_FORM, OPC_EXG}, 8'h4A, 1'b0, '0},
    '{{C_FORM, OPC_ADD}, 8'hFA, 1'b0, '0},
    '{{C_FORM, OPC_SUB}, 8'hF0, 1'b0, '0},
    '{{C_FORM, OPC_REST}, 8'h3F, 1'b0, '0},
    '{{C_FORM, OPC_MGET}, 8'h7E, 1'b0, '0},
    '{{C_FORM, OPC_MSET}, 8'hF9, 1'b0, '0},
    '{EXT_OP, {DX_MCALL, 4'hF}, 1'b0, '0},
    '{{A_FORM, AF_LOOP, 4'd3}, 8'h20, 1'b0, '0},
    '{EXT_OP, {DX_PUSH, 4'd15}, 1'b0, '0},
    '{EXT_OP, {DX_POP, 4'd14}, 1'b0, '0},
    '{{C_FORM, OPC_CALL}, 8'h07, 1'b0, '0},
    '{EXT_OP, {DX_SYS, SY_RET}, 1'b0, '0},
    '{EXT_OP, {DX_SYS, SY_NOP}, 1'b0, '0},
    '{EXT_OP, {DX_SYS, SY_SLUR_OFF}, 1'b0, '0},
    '{EXT_OP, {DX_SYS, SY_HALT}, 1'b0, '0}
  };

  // Execute one instruction on the predictor state, return its result
  function automatic mscc_result_t execute_instr(input logic [7:0] u, input logic [7:0] v);
    mscc_result_t r;
    logic [3:0]   n;
    logic [3:0]   x;
    logic [3:0]   y;
    logic         take;
    logic [7:0]   tmp;
    r    = '0;
    n    = u[3:0];
    x    = v[7:4];
    y    = v[3:0];
    take = 1'b0;
    fetch_ptr = fetch_ptr + 8'd1;
    if (u < 8'h80) begin
      if (u <= NOTE_REST_CODE) begin
        r.command_kind   = (u < NOTE_REST_CODE) ? KIND_PLAY : KIND_REST;
        r.pitch          = (u < NOTE_REST_CODE) ? u : 8'd0;
        r.length_count   = {4'd0, x} + 8'd1;
        r.length_divisor = {4'd0, y} + 8'd1;
      end else begin
        r.fault = FAULT_ILLEGAL;
      end
    end else if (u < 8'hC0) begin
      case (u[5:4])
        AF_LD: chan_regs[n] = v;
        AF_NOTE: begin
          r.command_kind   = KIND_PLAY;
          r.pitch          = chan_regs[n];
          r.length_count   = chan_regs[x];
          r.length_divisor = chan_regs[y];
        end
        AF_LOOP: begin
          if (chan_regs[n] != 8'd0) begin
            chan_regs[n] = chan_regs[n] - 8'd1;
            fetch_ptr    = v;
          end
        end
        default: r.fault = FAULT_ILLEGAL;
      endcase
    end else if (u != EXT_OP) begin
      case (u[5:0])
        OPC_CALL: begin
          if (stk_level + 2 > int'(STACK_SIZE)) begin
            r.fault = FAULT_STACK;
          end else begin
            stack_mem[stk_level]     = proc_num;
            stack_mem[stk_level + 1] = fetch_ptr;
            stk_level = stk_level + 2;
            proc_num  = v;
            fetch_ptr = 8'd0;
          end
        end
        OPC_JMP: take = 1'b1;
        OPC_JEQ: take = flag_eq;
        OPC_JNE: take = !flag_eq;
        OPC_JLE: take = flag_eq || !flag_gt;
        OPC_JLT: take = !flag_gt && !flag_eq;
        OPC_JGE: take = flag_eq || flag_gt;
        OPC_JGT: take = flag_gt;
        OPC_MOV: chan_regs[y] = chan_regs[x];
        OPC_EXG: begin
          tmp          = chan_regs[y];
          chan_regs[y] = chan_regs[x];
          chan_regs[x] = tmp;
        end
        OPC_ADD: chan_regs[y] = chan_regs[y] + chan_regs[x];
        OPC_SUB: chan_regs[y] = chan_regs[y] - chan_regs[x];
        OPC_PRC: chan_regs[y] = 8'((int'(chan_regs[y]) * int'(chan_regs[x])) / int'(PRC_DIV));
        OPC_CMP: begin
          flag_eq = (chan_regs[x] == chan_regs[y]);
          flag_gt = (chan_regs[x] < chan_regs[y]);
        end
        OPC_REST: begin
          r.command_kind   = KIND_REST;
          r.length_count   = chan_regs[x];
          r.length_divisor = chan_regs[y];
        end
        OPC_MGET: begin
          r.module_request = MREQ_GET;
          r.module_slot    = x;
        end
        OPC_MSET: begin
          r.module_request = MREQ_SET;
          r.module_slot    = y;
          r.module_data    = chan_regs[x];
        end
        default: r.fault = FAULT_ILLEGAL;
      endcase
      if (take) fetch_ptr = v;
    end else if (x != DX_SYS) begin
      case (x)
        DX_PUSH: begin
          if (stk_level >= int'(STACK_SIZE)) begin
            r.fault = FAULT_STACK;
          end else begin
            stack_mem[stk_level] = chan_regs[y];
            stk_level = stk_level + 1;
          end
        end
        DX_POP: begin
          if (stk_level == 0) begin
            r.fault = FAULT_STACK;
          end else begin
            stk_level    = stk_level - 1;
            chan_regs[y] = stack_mem[stk_level];
          end
        end
        DX_MCALL: begin
          r.module_request = MREQ_CALL;
          r.module_slot    = y;
        end
        default: r.fault = FAULT_ILLEGAL;
      endcase
    end else begin
      case (y)
        SY_NOP: ;
        SY_RET: begin
          if (stk_level < 2) begin
            r.fault = FAULT_STACK;
          end else begin
            fetch_ptr = stack_mem[stk_level - 1];
            proc_num  = stack_mem[stk_level - 2];
            stk_level = stk_level - 2;
          end
        end
        SY_SLUR_ON:  slur_mode = 1'b1;
        SY_SLUR_OFF: slur_mode = 1'b0;
        SY_HALT:     r.command_kind = KIND_HALT;
        default:     r.fault = FAULT_ILLEGAL;
      endcase
    end
    r.next_fetch = fetch_ptr;
    r.procedure  = proc_num;
    r.slur_on    = slur_mode;
    return r;
  endfunction

  task automatic queue_instr(input logic [7:0] op, input logic [7:0] arg);
    instr_queue.push_back({arg, op});
  endtask

  // Plan one random burst of instructions
  task automatic plan_burst();
    int         pick;
    int         cnt;
    logic [3:0] reg_n;
    logic [7:0] arg;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // direct notes and rests
      cnt = $urandom_range(1, 4);
      repeat (cnt) queue_instr(8'($urandom_range(0, int'(NOTE_REST_CODE))), 8'($urandom));
    end else if (pick < 25) begin
      // loads, half of them small values
      arg = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      queue_instr({A_FORM, AF_LD, 4'($urandom)}, arg);
    end else if (pick < 30) begin
      queue_instr({A_FORM, AF_NOTE, 4'($urandom)}, 8'($urandom));
    end else if (pick < 40) begin
      // register arithmetic, move, exchange, percent and compare
      queue_instr({C_FORM, OPC_MOV + 6'($urandom_range(0, 5))}, 8'($urandom));
    end else if (pick < 52) begin
      // compare followed by conditional and unconditional jumps, sometimes with equal operands
      arg = 8'($urandom);
      if ($urandom_range(0, 2) == 0) arg[3:0] = arg[7:4];
      queue_instr({C_FORM, OPC_CMP}, arg);
      cnt = $urandom_range(1, 3);
      repeat (cnt) queue_instr({C_FORM, OPC_JMP + 6'($urandom_range(0, 6))}, 8'($urandom));
    end else if (pick < 58) begin
      // counted loop run down past zero
      reg_n = 4'($urandom);
      cnt   = $urandom_range(0, 3);
      queue_instr({A_FORM, AF_LD, reg_n}, 8'(cnt));
      repeat (cnt + 1) queue_instr({A_FORM, AF_LOOP, reg_n}, 8'($urandom));
    end else if (pick < 66) begin
      // push run, then pop run; long runs hit overflow and underflow
      cnt = $urandom_range(1, 36);
      repeat (cnt) queue_instr(EXT_OP, {DX_PUSH, 4'($urandom)});
      cnt = $urandom_range(0, 36);
      repeat (cnt) queue_instr(EXT_OP, {DX_POP, 4'($urandom)});
    end else if (pick < 72) begin
      // nested calls, then returns
      cnt = $urandom_range(1, 18);
      repeat (cnt) queue_instr({C_FORM, OPC_CALL}, 8'($urandom));
      cnt = $urandom_range(0, 18);
      repeat (cnt) queue_instr(EXT_OP, {DX_SYS, SY_RET});
    end else if (pick < 80) begin
      // register rest and module requests
      case ($urandom_range(0, 3))
        0:       queue_instr({C_FORM, OPC_REST}, 8'($urandom));
        1:       queue_instr({C_FORM, OPC_MGET}, 8'($urandom));
        2:       queue_instr({C_FORM, OPC_MSET}, 8'($urandom));
        default: queue_instr(EXT_OP, {DX_MCALL, 4'($urandom)});
      endcase
    end else if (pick < 88) begin
      case ($urandom_range(0, 3))
        0:       queue_instr(EXT_OP, {DX_SYS, SY_NOP});
        1:       queue_instr(EXT_OP, {DX_SYS, SY_SLUR_ON});
        2:       queue_instr(EXT_OP, {DX_SYS, SY_SLUR_OFF});
        default: queue_instr(EXT_OP, {DX_SYS, SY_HALT});
      endcase
    end else begin
      // raw noise over the whole encoding space
      queue_instr(8'($urandom), 8'($urandom));
    end
  endtask

  // Offer one request, wait for the handshake, then predict its result
  task automatic send_instr(input logic [7:0] op, input logic [7:0] arg,
                            input bit typed, input mscc_result_t want);
    mscc_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {arg, op};
    do @(posedge clk); while (!s_ready);
    pred = execute_instr(op, arg);
    predicted_steps.push_back(typed ? want : pred);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Result side ready: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      stall_left    <= HOLD_CYCLES;
      m_ready       <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_ready    <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      if (predicted_steps.size() == 0) begin
        $error("unexpected result: tuser %0d tdata %h", m_tuser, m_tdata);
        error_count++;
      end else begin
        want_step = predicted_steps.pop_front();
        compare_field("command_kind",   want_step.command_kind,   m_tuser[1:0]);
        compare_field("pitch",          want_step.pitch,          m_tdata[7:0]);
        compare_field("length_count",   want_step.length_count,   m_tdata[15:8]);
        compare_field("length_divisor", want_step.length_divisor, m_tdata[23:16]);
        compare_field("next_fetch",     want_step.next_fetch,     m_tdata[31:24]);
        compare_field("procedure",      want_step.procedure,      m_tdata[39:32]);
        compare_field("slur_on",        want_step.slur_on,        m_tdata[40]);
        compare_field("module_request", want_step.module_request, m_tdata[42:41]);
        compare_field("module_slot",    want_step.module_slot,    m_tdata[46:43]);
        compare_field("module_data",    want_step.module_data,    m_tdata[54:47]);
        compare_field("fault",          want_step.fault,          m_tdata[56:55]);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Main sequence
  initial begin
    int sent;
    foreach (chan_regs[i]) chan_regs[i] = '0;
    foreach (stack_mem[i]) stack_mem[i] = '0;
    flag_eq   = 1'b0;
    flag_gt   = 1'b0;
    slur_mode = 1'b0;
    fetch_ptr = '0;
    proc_num  = '0;
    stk_level = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_instr(directed_rows[i].op, directed_rows[i].arg,
                 directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = phase_send_idle[ph];
      recv_stall_pct = phase_recv_stall[ph];
      // long result hold-off while requests keep coming
      if (ph == 0) holds_asked++;
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        plan_burst();
        while (instr_queue.size() != 0) begin
          send_instr(instr_queue[0][7:0], instr_queue[0][15:8], 1'b0, '0);
          void'(instr_queue.pop_front());
          sent++;
        end
      end
    end
    s_valid <= 1'b0;

    while (predicted_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
